### hw/rtl/agcs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// agcs_pkg - shared types and constants of the coprocessor task scheduler
// Event, result and slot layouts, status and run-kind codes, register indexes.
// ---------------------------------------------------------------------------
package agcs_pkg;

    localparam int TASK_ID_BITS = 8;
    localparam int QUEUE_DEPTH  = 16;
    localparam int FILL_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_BITS = 2;
    localparam int RCNT_BITS    = 7;
    localparam int FRAME_BITS   = 32;
    localparam logic [RCNT_BITS-1:0] RESET_LIMIT = 7'd100;

    // event codes
    typedef enum logic [2:0] {
        ACT_FRAME_TICK  = 3'd0,
        ACT_RSP_DONE    = 3'd1,
        ACT_RDP_DONE    = 3'd2,
        ACT_QUEUE_TASK  = 3'd3,
        ACT_QUEUE_AUDIO = 3'd4,
        ACT_QUEUE_GFX   = 3'd5,
        ACT_PRERESET    = 3'd6
    } action_t;

    // task status codes
    typedef enum logic [2:0] {
        ST_WAITING = 3'd0,
        ST_RUNNING = 3'd1,
        ST_YIELDED = 3'd2,
        ST_RSPDONE = 3'd3,
        ST_RDPDONE = 3'd4
    } status_t;

    // which kind of task owns the coprocessor
    typedef enum logic [1:0] {
        RUN_NONE  = 2'd0,
        RUN_AUDIO = 2'd1,
        RUN_GFX   = 2'd2
    } run_kind_t;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_AUDIO_ENABLE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AUDIO_CLIENT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GFX_CLIENT   = 2'd2;

    typedef struct packed {
        logic                    valid;
        logic                    notice;
        logic [TASK_ID_BITS-1:0] id;
    } slot_t;

    typedef struct packed {
        logic [2:0]              action;
        logic [TASK_ID_BITS-1:0] task_id;
        logic                    task_is_graphics;
        logic                    wants_notice;
        logic                    was_yielded;
    } event_t;

    typedef struct packed {
        logic                    start_valid;
        logic [TASK_ID_BITS-1:0] start_id;
        logic                    start_is_graphics;
        logic                    yield_request;
        logic                    notice_valid;
        logic [TASK_ID_BITS-1:0] notice_id;
        logic                    audio_client_tick;
        logic                    graphics_client_tick;
        logic                    queue_drop;
        logic [RCNT_BITS-1:0]    reset_count;
        logic [FRAME_BITS-1:0]   frame_count;
    } result_t;

endpackage

### hw/rtl/audio_graphics_coprocessor_scheduler.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// audio_graphics_coprocessor_scheduler - audio/graphics task scheduler
// Schedules audio and graphics tasks on a shared coprocessor from a stream
// of events; one result item per event.
//
//   channel | direction | handshake              | carries
//   --------+-----------+------------------------+------------------------
//   s_      | in        | s_valid / s_ready      | one event item
//   m_      | out       | m_valid / m_ready      | one result item
//   cfg_    | in        | cfg_valid / cfg_ready  | register index and data
//
// One item per cycle sustained while m_ready is high; an accepted event waits in
// the input register, then its result loads into the result register that drives m_.
// Reset (aresetn low at a clock edge) empties both registers and all slots.
// A stalled result holds the result register; the input register still takes
// one more item, and the block stops accepting only when both are full.
// cfg_ready is always high.
// ---------------------------------------------------------------------------
module audio_graphics_coprocessor_scheduler (
    input  logic                              aclk,
    input  logic                              aresetn,
    // event channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [2:0]                        s_action,
    input  logic [agcs_pkg::TASK_ID_BITS-1:0] s_task_id,
    input  logic                              s_task_is_graphics,
    input  logic                              s_wants_notice,
    input  logic                              s_was_yielded,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_start_valid,
    output logic [agcs_pkg::TASK_ID_BITS-1:0] m_start_id,
    output logic                              m_start_is_graphics,
    output logic                              m_yield_request,
    output logic                              m_notice_valid,
    output logic [agcs_pkg::TASK_ID_BITS-1:0] m_notice_id,
    output logic                              m_audio_client_tick,
    output logic                              m_graphics_client_tick,
    output logic                              m_queue_drop,
    output logic [agcs_pkg::RCNT_BITS-1:0]    m_reset_count,
    output logic [agcs_pkg::FRAME_BITS-1:0]   m_frame_count,
    // configuration channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [agcs_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic                              cfg_data
);
    import agcs_pkg::*;

    event_t  s_item, item;
    result_t res, m_item;
    logic    item_valid, out_free, fire;

    // pack the event fields
    assign s_item = '{action:           s_action,
                      task_id:          s_task_id,
                      task_is_graphics: s_task_is_graphics,
                      wants_notice:     s_wants_notice,
                      was_yielded:      s_was_yielded};

    // an item moves on when the result register can take its result
    assign fire = item_valid && out_free;

    agcs_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .pop        (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    agcs_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .evt       (item),
        .res       (res)
    );

    agcs_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .res_in   (res),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

    // unpack the result fields
    assign m_start_valid          = m_item.start_valid;
    assign m_start_id             = m_item.start_id;
    assign m_start_is_graphics    = m_item.start_is_graphics;
    assign m_yield_request        = m_item.yield_request;
    assign m_notice_valid         = m_item.notice_valid;
    assign m_notice_id            = m_item.notice_id;
    assign m_audio_client_tick    = m_item.audio_client_tick;
    assign m_graphics_client_tick = m_item.graphics_client_tick;
    assign m_queue_drop           = m_item.queue_drop;
    assign m_reset_count          = m_item.reset_count;
    assign m_frame_count          = m_item.frame_count;

endmodule

### hw/rtl/agcs_in_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// agcs_in_stage - input register of the scheduler
// Holds one accepted event until the scheduling logic consumes it.
// ---------------------------------------------------------------------------
module agcs_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  agcs_pkg::event_t s_item,
    input  logic            pop,
    output logic            item_valid,
    output agcs_pkg::event_t item
);
    import agcs_pkg::*;

    logic   valid_reg, valid_next;
    event_t item_reg;
    logic   take;

    // room when empty or when the held item leaves this cycle
    assign s_ready    = !valid_reg || pop;
    assign take       = s_valid && s_ready;
    assign valid_next = take || (valid_reg && !pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### hw/rtl/agcs_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// agcs_engine - scheduler state and per-event update
// Keeps task slots, message queue, statuses and counters; computes one
// result and the next state for the event in the input register.
// ---------------------------------------------------------------------------
module agcs_engine (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [agcs_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic                              cfg_data,
    input  logic                              fire,
    input  agcs_pkg::event_t                  evt,
    output agcs_pkg::result_t                 res
);
    import agcs_pkg::*;

    // configuration
    logic audio_enable_reg, audio_client_reg, gfx_client_reg;

    // scheduler state
    logic [FILL_BITS-1:0]  fill_reg, fill_next;
    slot_t                 q_audio_reg, q_audio_next;
    slot_t                 q_gfx_reg, q_gfx_next;
    slot_t                 a_cur_reg, a_cur_next;
    slot_t                 a_nxt_reg, a_nxt_next;
    slot_t                 g_cur_reg, g_cur_next;
    slot_t                 g_nxt_reg, g_nxt_next;
    status_t               a_st_reg, a_st_next;
    status_t               g_st_reg, g_st_next;
    status_t               r_st_reg, r_st_next;
    logic                  det_reg, det_next;
    run_kind_t             run_kind_reg, run_kind_next;
    logic [RCNT_BITS-1:0]  rcnt_reg, rcnt_next;
    logic [FRAME_BITS-1:0] frame_counter_reg, frame_counter_next;

    // working signals of the update
    slot_t   slot_in;
    status_t cur_st, new_st;
    logic    run_audio_req, fin_req, start_g_req, enq_req, enq_gfx;

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            audio_enable_reg <= 1'b1;
            audio_client_reg <= 1'b0;
            gfx_client_reg   <= 1'b0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_AUDIO_ENABLE) begin
                audio_enable_reg <= cfg_data;
            end
            if (cfg_index == CFG_AUDIO_CLIENT) begin
                audio_client_reg <= cfg_data;
            end
            if (cfg_index == CFG_GFX_CLIENT) begin
                gfx_client_reg <= cfg_data;
            end
        end
    end

    // event handling
    always_comb begin
        slot_in            = '{valid: 1'b1, notice: evt.wants_notice, id: evt.task_id};
        fill_next          = fill_reg;
        q_audio_next       = q_audio_reg;
        q_gfx_next         = q_gfx_reg;
        a_cur_next         = a_cur_reg;
        a_nxt_next         = a_nxt_reg;
        g_cur_next         = g_cur_reg;
        g_nxt_next         = g_nxt_reg;
        a_st_next          = a_st_reg;
        g_st_next          = g_st_reg;
        r_st_next          = r_st_reg;
        det_next           = det_reg;
        run_kind_next      = run_kind_reg;
        rcnt_next          = rcnt_reg;
        frame_counter_next = frame_counter_reg;
        cur_st             = ST_WAITING;
        new_st             = ST_WAITING;
        run_audio_req      = 1'b0;
        fin_req            = 1'b0;
        start_g_req        = 1'b0;
        enq_req            = 1'b0;
        enq_gfx            = 1'b0;
        res                = '0;

        unique case (evt.action)
            ACT_FRAME_TICK: begin
                frame_counter_next = frame_counter_reg + 32'd1;
                if (rcnt_reg != '0 && rcnt_reg < RESET_LIMIT) begin
                    rcnt_next = rcnt_reg + 7'd1;
                end
                // move queued tasks into the next slots, then promote
                if (q_audio_reg.valid) begin
                    a_nxt_next = q_audio_reg;
                end
                if (q_gfx_reg.valid) begin
                    g_nxt_next = q_gfx_reg;
                end
                q_audio_next = '0;
                q_gfx_next   = '0;
                fill_next    = '0;
                if (!a_cur_next.valid && a_nxt_next.valid) begin
                    a_cur_next = a_nxt_next;
                    a_st_next  = ST_WAITING;
                    a_nxt_next = '0;
                end
                if (!g_cur_next.valid && g_nxt_next.valid) begin
                    g_cur_next = g_nxt_next;
                    g_st_next  = ST_WAITING;
                    g_nxt_next = '0;
                end
                // audio preempts graphics
                if (a_cur_next.valid) begin
                    if (run_kind_reg == RUN_GFX) begin
                        if (det_reg) begin
                            r_st_next = ST_YIELDED;
                        end else begin
                            g_st_next = ST_YIELDED;
                        end
                        res.yield_request = 1'b1;
                    end else if (run_kind_reg == RUN_NONE) begin
                        run_audio_req = 1'b1;
                    end
                end else if (run_kind_reg == RUN_NONE) begin
                    if (g_cur_next.valid && g_st_next != ST_RSPDONE) begin
                        start_g_req = 1'b1;
                    end
                end
                res.audio_client_tick    = audio_client_reg;
                res.graphics_client_tick = gfx_client_reg;
            end
            ACT_RSP_DONE: begin
                if (run_kind_reg != RUN_NONE) begin
                    if (run_kind_reg == RUN_AUDIO) begin
                        cur_st = a_st_reg;
                    end else if (det_reg) begin
                        cur_st = r_st_reg;
                    end else begin
                        cur_st = g_st_reg;
                    end
                    // a yield that saved state keeps its status
                    new_st = (cur_st == ST_YIELDED && evt.was_yielded) ? cur_st : ST_RSPDONE;
                    if (run_kind_reg == RUN_AUDIO) begin
                        a_st_next = new_st;
                    end else if (det_reg) begin
                        r_st_next = new_st;
                    end else begin
                        g_st_next = new_st;
                    end
                    run_kind_next = RUN_NONE;
                    if (cur_st == ST_YIELDED) begin
                        run_audio_req = 1'b1;
                    end else if (run_kind_reg == RUN_AUDIO) begin
                        fin_req = 1'b1;
                    end
                end
            end
            ACT_RDP_DONE: begin
                if (g_cur_reg.valid) begin
                    if (g_cur_reg.notice) begin
                        res.notice_valid = 1'b1;
                        res.notice_id    = g_cur_reg.id;
                    end
                    // running graphics task keeps its own status from here
                    if (run_kind_reg == RUN_GFX && !det_reg) begin
                        det_next  = 1'b1;
                        r_st_next = ST_RDPDONE;
                    end
                    g_cur_next = '0;
                    g_st_next  = ST_WAITING;
                end
            end
            ACT_QUEUE_TASK: begin
                enq_req = 1'b1;
                enq_gfx = evt.task_is_graphics;
            end
            ACT_QUEUE_AUDIO: begin
                enq_req = audio_enable_reg;
            end
            ACT_QUEUE_GFX: begin
                if (!g_cur_reg.valid) begin
                    g_cur_next  = slot_in;
                    g_st_next   = ST_WAITING;
                    g_nxt_next  = '0;
                    start_g_req = (run_kind_reg == RUN_NONE);
                end else begin
                    g_nxt_next = slot_in;
                end
            end
            ACT_PRERESET: begin
                rcnt_next = 7'd1;
            end
            default: begin
            end
        endcase

        // bounded message queue, last task of each kind wins
        if (enq_req) begin
            if (fill_reg >= FILL_BITS'(QUEUE_DEPTH)) begin
                res.queue_drop = 1'b1;
            end else begin
                fill_next = fill_reg + 1'b1;
                if (enq_gfx) begin
                    q_gfx_next = slot_in;
                end else begin
                    q_audio_next = slot_in;
                end
            end
        end

        // run or skip the current audio task
        if (run_audio_req) begin
            run_kind_next = RUN_NONE;
            if (audio_enable_reg) begin
                if (a_cur_next.valid) begin
                    run_kind_next         = RUN_AUDIO;
                    a_st_next             = ST_RUNNING;
                    res.start_valid       = 1'b1;
                    res.start_id          = a_cur_next.id;
                    res.start_is_graphics = 1'b0;
                end
            end else if (a_cur_next.valid) begin
                a_st_next = ST_RSPDONE;
                fin_req   = 1'b1;
            end
        end

        // audio finished: resume graphics, send notice, free slot
        if (fin_req) begin
            if (g_cur_next.valid && g_st_next != ST_RSPDONE) begin
                start_g_req = 1'b1;
            end
            if (a_cur_next.valid && a_cur_next.notice) begin
                res.notice_valid = 1'b1;
                res.notice_id    = a_cur_next.id;
            end
            a_cur_next = '0;
            a_st_next  = ST_WAITING;
        end

        // start the current graphics task
        if (start_g_req) begin
            run_kind_next         = RUN_GFX;
            det_next              = 1'b0;
            g_st_next             = ST_RUNNING;
            res.start_valid       = 1'b1;
            res.start_id          = g_cur_next.id;
            res.start_is_graphics = 1'b1;
        end

        res.reset_count = rcnt_next;
        res.frame_count = frame_counter_next;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg          <= '0;
            q_audio_reg       <= '0;
            q_gfx_reg         <= '0;
            a_cur_reg         <= '0;
            a_nxt_reg         <= '0;
            g_cur_reg         <= '0;
            g_nxt_reg         <= '0;
            a_st_reg          <= ST_WAITING;
            g_st_reg          <= ST_WAITING;
            r_st_reg          <= ST_WAITING;
            det_reg           <= 1'b0;
            run_kind_reg      <= RUN_NONE;
            rcnt_reg          <= '0;
            frame_counter_reg <= '0;
        end else if (fire) begin
            fill_reg          <= fill_next;
            q_audio_reg       <= q_audio_next;
            q_gfx_reg         <= q_gfx_next;
            a_cur_reg         <= a_cur_next;
            a_nxt_reg         <= a_nxt_next;
            g_cur_reg         <= g_cur_next;
            g_nxt_reg         <= g_nxt_next;
            a_st_reg          <= a_st_next;
            g_st_reg          <= g_st_next;
            r_st_reg          <= r_st_next;
            det_reg           <= det_next;
            run_kind_reg      <= run_kind_next;
            rcnt_reg          <= rcnt_next;
            frame_counter_reg <= frame_counter_next;
        end
    end

    // queue never overfills
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_BITS'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    // reset counter saturates
    a_rcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rcnt_reg <= RESET_LIMIT)
        else $error("reset counter above limit");

    // a running audio task always has a slot
    a_audio_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        run_kind_reg == RUN_AUDIO |-> a_cur_reg.valid)
        else $error("audio running without a current slot");

    // an empty audio slot is always waiting
    a_audio_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !a_cur_reg.valid |-> a_st_reg == ST_WAITING)
        else $error("empty audio slot with non-waiting status");

    // each frame tick advances the frame counter by one
    a_frame_step: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && evt.action == ACT_FRAME_TICK
        |=> frame_counter_reg == $past(frame_counter_reg) + 32'd1)
        else $error("frame counter did not advance");

endmodule

### hw/rtl/agcs_out_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// agcs_out_stage - result register of the scheduler
// Holds one result item until the downstream side takes it.
// ---------------------------------------------------------------------------
module agcs_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  agcs_pkg::result_t  res_in,
    output logic               out_free,
    output logic               m_valid,
    input  logic               m_ready,
    output agcs_pkg::result_t  m_item
);
    import agcs_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    // free when empty or when the held item is taken now
    assign out_free   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = res_reg;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top - self-checking bench for the coprocessor task scheduler
// Drives scheduler events over the s_ channel and compares every result item
// with an in-bench model of the task slots, the message queue and the task
// status. A short directed sequence is followed by random episodes under
// several register settings and idle and stall patterns.
// ---------------------------------------------------------------------------
module tb_top;
    import agcs_pkg::*;

    localparam logic [2:0] ACT_UNDEFINED  = 3'd7;
    localparam int         NUM_PHASES     = 8;
    localparam int         PHASE_ITEMS    = 192;
    localparam int         PRESSURE_PHASE = 4;
    localparam int         HOLD_CYCLES    = 80;
    localparam int         STALL_LIMIT    = 1000;
    // per phase {audio_enable, audio_client_on, graphics_client_on}, phase 0 in the low bits
    localparam logic [NUM_PHASES*3-1:0] PHASE_SETTINGS =
        {3'b011, 3'b110, 3'b000, 3'b101, 3'b001, 3'b010, 3'b111, 3'b100};

    typedef struct packed {
        event_t                ev;
        logic                  typed;
        logic [RCNT_BITS-1:0]  rc;
        logic [FRAME_BITS-1:0] fc;
    } directed_row_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [2:0]              s_action;
    logic [TASK_ID_BITS-1:0] s_task_id;
    logic                    s_task_is_graphics;
    logic                    s_wants_notice;
    logic                    s_was_yielded;
    logic                    m_valid;
    logic                    m_ready;
    logic                    m_start_valid;
    logic [TASK_ID_BITS-1:0] m_start_id;
    logic                    m_start_is_graphics;
    logic                    m_yield_request;
    logic                    m_notice_valid;
    logic [TASK_ID_BITS-1:0] m_notice_id;
    logic                    m_audio_client_tick;
    logic                    m_graphics_client_tick;
    logic                    m_queue_drop;
    logic [RCNT_BITS-1:0]    m_reset_count;
    logic [FRAME_BITS-1:0]   m_frame_count;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic                    cfg_data;

    // scheduler model state
    logic                  cfg_audio_en, cfg_audio_client, cfg_gfx_client;
    slot_t                 q_audio, q_gfx, aud_cur, aud_nxt, gfx_cur, gfx_nxt;
    status_t               aud_st, gfx_st, detached_st;
    run_kind_t             runner;
    logic                  detached;
    logic [FILL_BITS-1:0]  queue_used;
    logic [RCNT_BITS-1:0]  reset_frames;
    logic [FRAME_BITS-1:0] frame_total;
    result_t               sched_out;

    result_t       sched_results_due[$];
    event_t        episode_events[$];
    directed_row_t directed_rows[$];
    int            mismatch_count = 0;
    int            phase_idx      = -1;
    int            sender_idle_pct = 0;
    int            rx_stall_pct    = 0;
    int            hold_left       = 0;
    bit            hold_done       = 0;

    audio_graphics_coprocessor_scheduler dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_action               (s_action),
        .s_task_id              (s_task_id),
        .s_task_is_graphics     (s_task_is_graphics),
        .s_wants_notice         (s_wants_notice),
        .s_was_yielded          (s_was_yielded),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_start_valid          (m_start_valid),
        .m_start_id             (m_start_id),
        .m_start_is_graphics    (m_start_is_graphics),
        .m_yield_request        (m_yield_request),
        .m_notice_valid         (m_notice_valid),
        .m_notice_id            (m_notice_id),
        .m_audio_client_tick    (m_audio_client_tick),
        .m_graphics_client_tick (m_graphics_client_tick),
        .m_queue_drop           (m_queue_drop),
        .m_reset_count          (m_reset_count),
        .m_frame_count          (m_frame_count),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // scheduler model
    // ------------------------------------------------------------------
    function automatic void reset_schedule();
        cfg_audio_en     = 1'b1;
        cfg_audio_client = 1'b0;
        cfg_gfx_client   = 1'b0;
        q_audio = '0; q_gfx = '0;
        aud_cur = '0; aud_nxt = '0; gfx_cur = '0; gfx_nxt = '0;
        aud_st = ST_WAITING; gfx_st = ST_WAITING; detached_st = ST_WAITING;
        runner       = RUN_NONE;
        detached     = 1'b0;
        queue_used   = '0;
        reset_frames = '0;
        frame_total  = '0;
    endfunction

    function automatic void launch_gfx();
        runner   = RUN_GFX;
        detached = 1'b0;
        gfx_st   = ST_RUNNING;
        sched_out.start_valid       = 1'b1;
        sched_out.start_id          = gfx_cur.id;
        sched_out.start_is_graphics = 1'b1;
    endfunction

    function automatic void launch_audio();
        if (!aud_cur.valid) begin
            runner = RUN_NONE;
            return;
        end
        runner = RUN_AUDIO;
        aud_st = ST_RUNNING;
        sched_out.start_valid       = 1'b1;
        sched_out.start_id          = aud_cur.id;
        sched_out.start_is_graphics = 1'b0;
    endfunction

    // audio task left the coprocessor: resume graphics, free the slot, notify
    function automatic void finish_audio();
        slot_t done_slot;
        done_slot = aud_cur;
        if (gfx_cur.valid && gfx_st != ST_RSPDONE)
            launch_gfx();
        aud_cur = '0;
        aud_st  = ST_WAITING;
        if (done_slot.valid && done_slot.notice) begin
            sched_out.notice_valid = 1'b1;
            sched_out.notice_id    = done_slot.id;
        end
    endfunction

    // with audio disabled the task counts as finished at once
    function automatic void dispatch_audio();
        if (cfg_audio_en) begin
            launch_audio();
        end else begin
            runner = RUN_NONE;
            if (!aud_cur.valid)
                return;
            aud_st = ST_RSPDONE;
            finish_audio();
        end
    endfunction

    function automatic status_t owner_status();
        if (runner == RUN_AUDIO)
            return aud_st;
        if (detached)
            return detached_st;
        return gfx_st;
    endfunction

    function automatic void set_owner_status(status_t st);
        if (runner == RUN_AUDIO)
            aud_st = st;
        else if (detached)
            detached_st = st;
        else
            gfx_st = st;
    endfunction

    function automatic void on_rsp_done(logic was_yielded);
        run_kind_t was_running;
        was_running = runner;
        if (was_running == RUN_NONE)
            return;
        if (owner_status() == ST_YIELDED) begin
            if (!was_yielded)
                set_owner_status(ST_RSPDONE);
            runner = RUN_NONE;
            dispatch_audio();
        end else begin
            set_owner_status(ST_RSPDONE);
            runner = RUN_NONE;
            if (was_running == RUN_AUDIO)
                finish_audio();
        end
    endfunction

    function automatic void on_rdp_done();
        if (!gfx_cur.valid)
            return;
        if (gfx_cur.notice) begin
            sched_out.notice_valid = 1'b1;
            sched_out.notice_id    = gfx_cur.id;
        end
        // a still running task keeps its own status once the slot is gone
        if (runner == RUN_GFX && !detached) begin
            detached    = 1'b1;
            detached_st = ST_RDPDONE;
        end
        gfx_cur = '0;
        gfx_st  = ST_WAITING;
    endfunction

    function automatic void on_frame_tick();
        frame_total = frame_total + 1'b1;
        if (reset_frames > 0 && reset_frames < RESET_LIMIT)
            reset_frames = reset_frames + 1'b1;
        // move queued tasks into next slots, promote into empty current slots
        if (q_audio.valid) aud_nxt = q_audio;
        if (q_gfx.valid)   gfx_nxt = q_gfx;
        q_audio    = '0;
        q_gfx      = '0;
        queue_used = '0;
        if (!aud_cur.valid && aud_nxt.valid) begin
            aud_cur = aud_nxt;
            aud_st  = ST_WAITING;
            aud_nxt = '0;
        end
        if (!gfx_cur.valid && gfx_nxt.valid) begin
            gfx_cur = gfx_nxt;
            gfx_st  = ST_WAITING;
            gfx_nxt = '0;
        end
        // pending audio preempts graphics
        if (aud_cur.valid) begin
            if (runner == RUN_GFX) begin
                set_owner_status(ST_YIELDED);
                sched_out.yield_request = 1'b1;
            end else if (runner == RUN_NONE) begin
                dispatch_audio();
            end
        end else if (runner == RUN_NONE) begin
            if (gfx_cur.valid && gfx_st != ST_RSPDONE)
                launch_gfx();
        end
        sched_out.audio_client_tick    = cfg_audio_client;
        sched_out.graphics_client_tick = cfg_gfx_client;
    endfunction

    function automatic void enqueue_task(slot_t slot, logic is_gfx);
        if (queue_used >= QUEUE_DEPTH) begin
            sched_out.queue_drop = 1'b1;
            return;
        end
        queue_used = queue_used + 1'b1;
        if (is_gfx)
            q_gfx = slot;
        else
            q_audio = slot;
    endfunction

    function automatic void post_gfx_direct(slot_t slot);
        if (!gfx_cur.valid) begin
            gfx_cur = slot;
            gfx_st  = ST_WAITING;
            gfx_nxt = '0;
            if (runner == RUN_NONE)
                launch_gfx();
        end else begin
            gfx_nxt = slot;
        end
    endfunction

    function automatic result_t schedule_event(event_t ev);
        slot_t incoming;
        sched_out       = '0;
        incoming.valid  = 1'b1;
        incoming.notice = ev.wants_notice;
        incoming.id     = ev.task_id;
        case (ev.action)
            ACT_FRAME_TICK:  on_frame_tick();
            ACT_RSP_DONE:    on_rsp_done(ev.was_yielded);
            ACT_RDP_DONE:    on_rdp_done();
            ACT_QUEUE_TASK:  enqueue_task(incoming, ev.task_is_graphics);
            ACT_QUEUE_AUDIO: if (cfg_audio_en) enqueue_task(incoming, 1'b0);
            ACT_QUEUE_GFX:   post_gfx_direct(incoming);
            ACT_PRERESET:    reset_frames = RCNT_BITS'(1);
            default: ;
        endcase
        sched_out.reset_count = reset_frames;
        sched_out.frame_count = frame_total;
        return sched_out;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic event_t rand_event(logic [2:0] act);
        event_t ev;
        ev.action           = act;
        ev.task_id          = TASK_ID_BITS'($urandom_range(255));
        ev.task_is_graphics = 1'($urandom_range(1));
        ev.wants_notice     = 1'($urandom_range(1));
        ev.was_yielded      = 1'($urandom_range(1));
        return ev;
    endfunction

    function automatic void add_row(logic [2:0] act, logic [TASK_ID_BITS-1:0] id,
                                    logic is_gfx, logic notice, logic yielded,
                                    logic typed, int rc, int fc);
        directed_row_t row;
        row.ev.action           = act;
        row.ev.task_id          = id;
        row.ev.task_is_graphics = is_gfx;
        row.ev.wants_notice     = notice;
        row.ev.was_yielded      = yielded;
        row.typed               = typed;
        row.rc                  = RCNT_BITS'(rc);
        row.fc                  = FRAME_BITS'(fc);
        directed_rows.push_back(row);
    endfunction

    // one burst of traffic, mostly shaped like real frames
    function automatic void plan_episode();
        int pick;
        int prereset_odds;
        pick = $urandom_range(99);
        prereset_odds = (reset_frames == 0 || reset_frames == RESET_LIMIT) ? 20 : 400;
        if ($urandom_range(prereset_odds - 1) == 0)
            episode_events.push_back(rand_event(ACT_PRERESET));
        if (pick < 70) begin
            // queue a few tasks, tick the frame, then coprocessor completions
            repeat ($urandom_range(3)) begin
                case ($urandom_range(2))
                    0:       episode_events.push_back(rand_event(ACT_QUEUE_TASK));
                    1:       episode_events.push_back(rand_event(ACT_QUEUE_AUDIO));
                    default: episode_events.push_back(rand_event(ACT_QUEUE_GFX));
                endcase
            end
            episode_events.push_back(rand_event(ACT_FRAME_TICK));
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(1))
                    episode_events.push_back(rand_event(ACT_RSP_DONE));
                else
                    episode_events.push_back(rand_event(ACT_RDP_DONE));
            end
        end else if (pick < 80) begin
            // 14 to 20 queued tasks in one frame, which can overflow the 16-entry queue
            repeat ($urandom_range(14, 20))
                episode_events.push_back(rand_event(ACT_QUEUE_TASK));
        end else begin
            repeat ($urandom_range(1, 4))
                episode_events.push_back(rand_event(3'($urandom_range(7))));
        end
    endfunction

    // present one item, hold it until accepted
    task automatic offer_event(event_t ev);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_action           <= ev.action;
        s_task_id          <= ev.task_id;
        s_task_is_graphics <= ev.task_is_graphics;
        s_wants_notice     <= ev.wants_notice;
        s_was_yielded      <= ev.was_yielded;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic program_regs(logic en, logic ac, logic gc);
        logic [CFG_IDX_BITS-1:0] idx [3];
        logic                    val [3];
        idx = '{CFG_AUDIO_ENABLE, CFG_AUDIO_CLIENT, CFG_GFX_CLIENT};
        val = '{en, ac, gc};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cfg_audio_en     = en;
        cfg_audio_client = ac;
        cfg_gfx_client   = gc;
    endtask

    // all due results seen, then a further idle wait
    task automatic wait_drained(int extra);
        while (sched_results_due.size() != 0)
            @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic report_fault(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("[%0t] mismatch: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    task automatic compare_result(result_t want);
        if (m_start_valid !== want.start_valid)
            report_fault("start_valid", 32'(m_start_valid), 32'(want.start_valid));
        if (m_start_id !== want.start_id)
            report_fault("start_id", 32'(m_start_id), 32'(want.start_id));
        if (m_start_is_graphics !== want.start_is_graphics)
            report_fault("start_is_graphics", 32'(m_start_is_graphics),
                         32'(want.start_is_graphics));
        if (m_yield_request !== want.yield_request)
            report_fault("yield_request", 32'(m_yield_request), 32'(want.yield_request));
        if (m_notice_valid !== want.notice_valid)
            report_fault("notice_valid", 32'(m_notice_valid), 32'(want.notice_valid));
        if (m_notice_id !== want.notice_id)
            report_fault("notice_id", 32'(m_notice_id), 32'(want.notice_id));
        if (m_audio_client_tick !== want.audio_client_tick)
            report_fault("audio_client_tick", 32'(m_audio_client_tick),
                         32'(want.audio_client_tick));
        if (m_graphics_client_tick !== want.graphics_client_tick)
            report_fault("graphics_client_tick", 32'(m_graphics_client_tick),
                         32'(want.graphics_client_tick));
        if (m_queue_drop !== want.queue_drop)
            report_fault("queue_drop", 32'(m_queue_drop), 32'(want.queue_drop));
        if (m_reset_count !== want.reset_count)
            report_fault("reset_count", 32'(m_reset_count), 32'(want.reset_count));
        if (m_frame_count !== want.frame_count)
            report_fault("frame_count", m_frame_count, want.frame_count);
    endtask

    // ------------------------------------------------------------------
    // result side: check accepted items, random stalls, one long hold-off
    // ------------------------------------------------------------------
    initial begin : result_side
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (sched_results_due.size() == 0)
                    report_fault("result item with nothing due", m_frame_count, 0);
                else
                    compare_result(sched_results_due.pop_front());
            end
            if (phase_idx == PRESSURE_PHASE && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        directed_row_t row;
        result_t       due;
        event_t        ev;
        logic [2:0]    settings;
        aresetn            <= 1'b0;
        s_valid            <= 1'b0;
        s_action           <= '0;
        s_task_id          <= '0;
        s_task_is_graphics <= 1'b0;
        s_wants_notice     <= 1'b0;
        s_was_yielded      <= 1'b0;
        cfg_valid          <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= 1'b0;
        reset_schedule();

        // idle completions, unknown code, pre-reset, empty frame
        add_row(ACT_RSP_DONE,    8'h00, 0, 0, 1, 1, 0, 0);
        add_row(ACT_RDP_DONE,    8'h00, 0, 0, 0, 1, 0, 0);
        add_row(ACT_UNDEFINED,   8'hFF, 1, 1, 1, 1, 0, 0);
        add_row(ACT_PRERESET,    8'hA5, 1, 0, 1, 1, 1, 0);
        add_row(ACT_FRAME_TICK,  8'h5A, 0, 1, 0, 1, 2, 1);
        // audio then graphics through the queue, audio finishing resumes graphics
        add_row(ACT_QUEUE_TASK,  8'hFF, 1, 1, 0, 0, 0, 0);
        add_row(ACT_QUEUE_TASK,  8'h00, 0, 1, 0, 0, 0, 0);
        add_row(ACT_FRAME_TICK,  8'h00, 0, 0, 0, 0, 0, 0);
        add_row(ACT_FRAME_TICK,  8'h00, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RSP_DONE,    8'h00, 0, 0, 0, 0, 0, 0);
        // audio preempts graphics, saved yield
        add_row(ACT_QUEUE_AUDIO, 8'h55, 1, 0, 0, 0, 0, 0);
        add_row(ACT_FRAME_TICK,  8'h00, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RSP_DONE,    8'h00, 0, 0, 1, 0, 0, 0);
        add_row(ACT_RDP_DONE,    8'h00, 0, 0, 0, 0, 0, 0);
        // direct graphics, then rdp done while it still runs
        add_row(ACT_QUEUE_GFX,   8'h12, 0, 1, 0, 0, 0, 0);
        add_row(ACT_RSP_DONE,    8'h00, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RDP_DONE,    8'h00, 0, 0, 0, 0, 0, 0);
        add_row(ACT_QUEUE_GFX,   8'h34, 1, 0, 0, 0, 0, 0);
        add_row(ACT_FRAME_TICK,  8'h00, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RSP_DONE,    8'h00, 0, 0, 0, 0, 0, 0);
        add_row(ACT_FRAME_TICK,  8'h00, 0, 0, 0, 0, 0, 0);
        // yield that did not save state
        add_row(ACT_QUEUE_AUDIO, 8'hAA, 0, 1, 1, 0, 0, 0);
        add_row(ACT_FRAME_TICK,  8'h00, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RSP_DONE,    8'h00, 0, 0, 0, 0, 0, 0);
        add_row(ACT_RDP_DONE,    8'h00, 0, 0, 0, 0, 0, 0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            offer_event(row.ev);
            due = schedule_event(row.ev);
            if (row.typed) begin
                due             = '0;
                due.reset_count = row.rc;
                due.frame_count = row.fc;
            end
            sched_results_due.push_back(due);
        end
        s_valid <= 1'b0;

        // random phases, each under its own register setting and idle pattern
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained(4);
            settings  = PHASE_SETTINGS[p*3 +: 3];
            phase_idx = p;
            case (p % 4)
                0: begin sender_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin sender_idle_pct = 48; rx_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  rx_stall_pct = 48; end
                default: begin sender_idle_pct = 25; rx_stall_pct = 25; end
            endcase
            program_regs(settings[2], settings[1], settings[0]);
            episode_events.delete();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (episode_events.size() == 0)
                    plan_episode();
                ev = episode_events.pop_front();
                offer_event(ev);
                sched_results_due.push_back(schedule_event(ev));
            end
            s_valid <= 1'b0;
        end

        wait_drained(8);
        if (sched_results_due.size() != 0)
            report_fault("results never arrived", sched_results_due.size(), 0);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
hw/rtl/agcs_pkg.sv
hw/rtl/agcs_in_stage.sv
hw/rtl/agcs_engine.sv
hw/rtl/agcs_out_stage.sv
hw/rtl/audio_graphics_coprocessor_scheduler.sv
tb/tb_top.sv
